FILE: hdl/smp_pkg.sv
// shared types, constants and the frame checksum for the module port framer
package smp_pkg;

	localparam int unsigned SLOTS     = 4;
	localparam int unsigned SLOT_W    = $clog2(SLOTS);
	localparam int unsigned FRAME_LEN = SLOTS + 2;
	localparam int unsigned CNT_W     = $clog2(FRAME_LEN);
	localparam int unsigned QDEPTH    = 2;
	localparam int unsigned QPTR_W    = $clog2(QDEPTH);

	localparam logic [7:0] HEADER_RST     = 8'hFF;
	localparam logic [7:0] UNASSIGNED_RST = 8'hFE;
	localparam logic [7:0] REPORT_RST     = 8'hFC;
	localparam logic [7:0] COMMAND_RST    = 8'hFE;
	localparam logic [7:0] CHECK_MASK     = 8'hF0;

	typedef enum logic [1:0] {
		OP_SET   = 2'd0,
		OP_SEND  = 2'd1,
		OP_REPLY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_HEADER     = 2'd0,
		CFG_UNASSIGNED = 2'd1,
		CFG_REPORT     = 2'd2,
		CFG_SPARE      = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SEND = 2'b10
	} back_state_t;

	typedef enum logic {
		KIND_FRAME = 1'b0,
		KIND_REPLY = 1'b1
	} kind_t;

	typedef struct packed {
		op_t               op;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        value;
		logic [SLOT_W-1:0] ret;
		logic              rvalid;
		logic [7:0]        rbyte;
	} cmd_t;

	function automatic logic [7:0] smp_checksum(input logic [SLOTS-1:0][7:0] cmds,
		input logic [SLOT_W-1:0] module_nr);
		logic [9:0]  sum;
		logic [10:0] fold;
		logic [7:0]  mix;
		sum = 10'd0;
		for (int i = 0; i < SLOTS; i++) begin
			sum = sum + {2'b00, cmds[i]};
		end
		fold = {1'b0, sum} + {9'd0, sum[9:8]};
		mix  = fold[7:0] + {fold[3:0], 4'h0};
		return (mix & CHECK_MASK) | {{(8-SLOT_W){1'b0}}, module_nr};
	endfunction

endpackage

FILE: hdl/smp_in_if.sv
// input word channel of the module port framer
interface smp_in_if;
	import smp_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [1:0] slot;
	logic [7:0] command_value;
	logic [3:0] return_module;
	logic       reply_valid;
	logic [7:0] reply_byte;

	modport source (output valid, opcode, slot, command_value, return_module,
		reply_valid, reply_byte, input ready);
	modport sink (input valid, opcode, slot, command_value, return_module,
		reply_valid, reply_byte, output ready);
endinterface

FILE: hdl/smp_out_if.sv
// result word channel of the module port framer
interface smp_out_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic [7:0] tx_byte;
	logic       frame_last;
	logic [1:0] reply_slot;
	logic [7:0] reply_echo;
	logic [7:0] stored_input;

	modport source (output valid, result_kind, tx_byte, frame_last, reply_slot,
		reply_echo, stored_input, input ready);
	modport sink (input valid, result_kind, tx_byte, frame_last, reply_slot,
		reply_echo, stored_input, output ready);
endinterface

FILE: hdl/smp_cfg_if.sv
// configuration write channel of the module port framer
interface smp_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/smp_front.sv
// front end: accepts input words, classifies them and hands them on
module smp_front import smp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	smp_in_if.sink   item_in,
	output logic     push_valid,
	input  logic     push_ready,
	output cmd_t     push_cmd
);

	logic valid_s1;
	cmd_t item_s1;
	cmd_t item_dec;
	logic take;

	always_comb begin
		item_dec.op     = op_t'(item_in.opcode);
		item_dec.slot   = item_in.slot;
		item_dec.value  = item_in.command_value;
		item_dec.ret    = (item_in.return_module < 4'(SLOTS)) ?
			item_in.return_module[SLOT_W-1:0] : '0;
		item_dec.rvalid = item_in.reply_valid;
		item_dec.rbyte  = item_in.reply_byte;
	end

	assign item_in.ready = !valid_s1 || push_ready;
	assign take          = item_in.valid && item_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= (item_dec.op != OP_NONE);
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_dec;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = item_s1;

endmodule

FILE: hdl/smp_queue.sv
// short queue between the front end and the back end
module smp_queue import smp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_cmd,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_cmd
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = mem_q[rptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_cmd;
		end
	end

endmodule

FILE: hdl/smp_back.sv
// back end: slot state, frame sequencing, reply handling and output register
module smp_back import smp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      pop_valid,
	output logic      pop_ready,
	input  cmd_t      pop_cmd,
	smp_cfg_if.sink   cfg,
	smp_out_if.source result_out
);

	logic [7:0]            header_q;
	logic [7:0]            unassigned_q;
	logic [7:0]            report_q;
	logic [SLOTS-1:0][7:0] cmds_q;
	logic [SLOT_W-1:0]     reply_module_q;
	back_state_t           state_q;
	logic [CNT_W-1:0]      cnt_q;

	logic                  out_valid_q;
	logic                  out_kind_q;
	logic [7:0]            out_tx_q;
	logic                  out_last_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic [7:0]            out_echo_q;
	logic [7:0]            out_stored_q;

	logic                  out_free;
	logic                  do_pop;
	logic [7:0]            check_byte;
	logic [SLOT_W-1:0]     cmd_idx;
	logic [7:0]            frame_byte;
	logic                  last_byte;
	logic [7:0]            stored_val;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q     <= HEADER_RST;
			unassigned_q <= UNASSIGNED_RST;
			report_q     <= REPORT_RST;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_HEADER:     header_q     <= cfg.data;
				CFG_UNASSIGNED: unassigned_q <= cfg.data;
				CFG_REPORT:     report_q     <= cfg.data;
				default: ;
			endcase
		end
	end

	assign out_free   = !out_valid_q || result_out.ready;
	assign pop_ready  = (state_q == ST_IDLE) && out_free;
	assign do_pop     = pop_valid && pop_ready;
	assign check_byte = smp_checksum(cmds_q, reply_module_q);
	assign cmd_idx    = SLOT_W'(cnt_q - 1'b1);
	assign last_byte  = (cnt_q == CNT_W'(FRAME_LEN - 1));
	assign stored_val = pop_cmd.rvalid ? pop_cmd.rbyte : 8'h00;

	always_comb begin
		if (cnt_q == '0) begin
			frame_byte = header_q;
		end else if (last_byte) begin
			frame_byte = check_byte;
		end else begin
			frame_byte = cmds_q[cmd_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cnt_q          <= '0;
			cmds_q         <= {SLOTS{COMMAND_RST}};
			reply_module_q <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (do_pop) begin
						case (pop_cmd.op)
							OP_SET: begin
								cmds_q[pop_cmd.slot] <= pop_cmd.value;
							end
							OP_SEND: begin
								reply_module_q <= pop_cmd.ret;
								cnt_q          <= '0;
								state_q        <= ST_SEND;
							end
							OP_REPLY: begin
								if (pop_cmd.rvalid && pop_cmd.rbyte == unassigned_q) begin
									cmds_q[reply_module_q] <= report_q;
								end
								out_valid_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_SEND: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						cnt_q       <= cnt_q + 1'b1;
						if (last_byte) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SEND && out_free) begin
			out_kind_q   <= KIND_FRAME;
			out_tx_q     <= frame_byte;
			out_last_q   <= last_byte;
			out_slot_q   <= '0;
			out_echo_q   <= 8'h00;
			out_stored_q <= 8'h00;
		end else if (do_pop && pop_cmd.op == OP_REPLY) begin
			out_kind_q   <= KIND_REPLY;
			out_tx_q     <= 8'h00;
			out_last_q   <= 1'b0;
			out_slot_q   <= reply_module_q;
			out_echo_q   <= pop_cmd.rbyte;
			out_stored_q <= stored_val;
		end
	end

	assign result_out.valid        = out_valid_q;
	assign result_out.result_kind  = out_kind_q;
	assign result_out.tx_byte      = out_tx_q;
	assign result_out.frame_last   = out_last_q;
	assign result_out.reply_slot   = out_slot_q;
	assign result_out.reply_echo   = out_echo_q;
	assign result_out.stored_input = out_stored_q;

	a_no_pop_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEND |-> !do_pop)
		else $error("queue popped during frame");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEND |-> cnt_q <= CNT_W'(FRAME_LEN - 1))
		else $error("frame counter out of range");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEND && out_free && last_byte |=> state_q == ST_IDLE)
		else $error("frame did not close after checksum");

	a_last_is_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> out_kind_q == KIND_FRAME)
		else $error("last flag on reply word");

endmodule

FILE: hdl/smart_module_port_framer.sv
// top level of the module port framer
// replies pass front register, queue and output register; frames also pass the send state
// throughput: a send item yields six words, one per cycle while the output is not stalled
// set and reply items complete in the back end when popped; a two-entry queue decouples
// the front end, so input stalls only when the queue and front register are full
// reset: asynchronous active low; slot commands 0xFE, registers to defaults, no clearing pass
module smart_module_port_framer import smp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	smp_in_if.sink    item_in,
	smp_cfg_if.sink   cfg,
	smp_out_if.source result_out
);

	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	smp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_in    (item_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	smp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_cmd   (push_cmd),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_cmd   (pop_cmd)
	);

	smp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd),
		.cfg        (cfg),
		.result_out (result_out)
	);

endmodule
